[rtl/euler_fly_camera_update_core_assert.svh]
// Assertion macros used by the checker of the fly camera core.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef EULER_FLY_CAMERA_UPDATE_CORE_ASSERT_SVH
`define EULER_FLY_CAMERA_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication.
`define ECU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ecu checker: same-cycle property failed");

// Next-cycle implication.
`define ECU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ecu checker: next-cycle property failed");

`endif

[rtl/ecu_pkg.sv]
// Shared constants, types and tables of the fly camera core.
// No dependencies; used by the controller, the datapath and the top level.
package ecu_pkg;

  localparam int VFB  = 14;          // fraction bits of the basis vectors
  localparam int VW   = VFB + 2;     // stored basis vector width
  localparam int S1   = 30 - VFB;    // rounding shift of a single trig term
  localparam int S2   = 60 - VFB;    // rounding shift of a trig product
  localparam int AW   = 25;          // yaw and folded angle width
  localparam int PW   = 24;          // pitch width
  localparam int POSW = 24;          // position width
  localparam int CW   = 34;          // CORDIC x and y width
  localparam int TW   = 32;          // stored sine and cosine width
  localparam int RW   = 35;          // yaw wrap accumulator width
  localparam int MW   = 33 + VW;     // move product width
  localparam int DW   = 216;         // result tdata width
  localparam int IW   = 56;          // input tdata width

  localparam int CORDIC_STEPS = 23;

  localparam logic signed [AW-1:0] QUARTER_TURN = 25'sd5898240;
  localparam logic signed [AW-1:0] HALF_TURN    = 25'sd11796480;
  localparam logic signed [RW-1:0] FULL_TURN    = 35'sd23592960;
  localparam logic signed [RW-1:0] HALF_TURN_R  = 35'sd11796480;
  localparam logic signed [33:0]   PITCH_LIMIT  = 34'sd5832704;
  localparam logic signed [AW-1:0] YAW_RESET    = -25'sd5898240;
  localparam logic signed [CW-1:0] CORDIC_X0    = 34'sd652032874;
  localparam logic signed [CW-1:0] TRIG_ONE     = 34'sd1073741824;
  localparam logic signed [POSW-1:0] POS_X_RESET = 24'sd0;
  localparam logic signed [POSW-1:0] POS_Y_RESET = 24'sd76800;
  localparam logic signed [POSW-1:0] POS_Z_RESET = 24'sd51200;
  localparam logic signed [POSW+1:0] POS_MAX    = 26'sd8388607;
  localparam logic signed [POSW+1:0] POS_MIN    = -26'sd8388608;

  localparam logic [15:0] SENS_RESET  = 16'd6554;
  localparam logic [15:0] SPEED_RESET = 16'd640;

  localparam logic OP_LOOK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic CFG_SENS  = 1'b0;
  localparam logic CFG_SPEED = 1'b1;

  localparam logic [2:0] DIR_FRONT_P = 3'd0;
  localparam logic [2:0] DIR_FRONT_N = 3'd1;
  localparam logic [2:0] DIR_UP_P    = 3'd2;
  localparam logic [2:0] DIR_UP_N    = 3'd3;
  localparam logic [2:0] DIR_RIGHT_N = 3'd4;
  localparam logic [2:0] DIR_RIGHT_P = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANG, ST_WRAP, ST_LOADY, ST_ITERY, ST_SAVEY,
    ST_LOADP, ST_ITERP, ST_SAVEP, ST_PROD, ST_MOVE, ST_DONE
  } state_e;

  typedef struct packed {
    logic       item_load;
    logic       look_upd;
    logic       vel_load;
    logic       wrap_step;
    logic       cordic_load;
    logic       cordic_step;
    logic       trig_save;
    logic       sel_pitch;
    logic       prod_step;
    logic       move_step;
    logic       out_load;
    logic [4:0] idx;
  } ecu_cmd_t;

  typedef struct packed {
    logic op_move;
    logic dir_valid;
  } ecu_stat_t;

  // atan(2^-i) in 1/65536 degree units.
  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    logic [22:0] v;
    case (i)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/euler_fly_camera_update_core.sv]
// Euler-angle fly camera core: top level joining controller and datapath.
// Depends on ecu_pkg, ecu_ctrl and ecu_dpath.
//
// The core keeps a yaw, a pitch, a camera position and the front, right and
// up vectors derived from the angles with world up fixed at +Y. A look item
// (tuser 0) scales the mouse offsets by the sensitivity register, wraps yaw
// into [-180, 180) degrees, clamps pitch to +-89 degrees and recomputes the
// vectors; a move item (tuser 1) steps the saturating position along one
// vector by speed times delta time. Every item returns one result item with
// the full state after the update. Sine and cosine come from one shared
// CORDIC unit that runs 23 rotations for yaw and then 23 for pitch, after
// the yaw wrap of a look item; a move item steps the position one axis at
// a time, and a move with an unused direction skips those steps. After
// reset the core runs the same vector computation for the reset angles
// and holds s_axis_tready low until done. A finished result waits in an
// output register, so the next item can be accepted while the previous
// result is not yet taken. The user must write configuration through
// cfg_we_i only while the core is idle; the core does not enforce this.
// A write applies to the next item and does not recompute the vectors.
module euler_fly_camera_update_core import ecu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // look_dx[15:0], look_dy[31:16], move_dir[34:32], delta_time[50:35], zero fill
  input  logic [IW-1:0] s_axis_tdata,
  // opcode
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x, pos_y, pos_z (24 bits each), then front_x..z, right_x..z,
  // up_x..z (16 bits each), from the lowest bit up
  output logic [DW-1:0] m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  ecu_cmd_t  cmd;
  ecu_stat_t stat;

  ecu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ecu_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule

[rtl/ecu_ctrl.sv]
// Sequencing state machine of the fly camera core.
// Depends on ecu_pkg; drives the datapath through ecu_cmd_t.
module ecu_ctrl import ecu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ecu_stat_t stat_i,
  output ecu_cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       init_q, init_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOADY;
      cnt_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = '0;
    init_d      = init_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.idx   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        if (stat_i.op_move) begin
          cmd_o.vel_load = 1'b1;
          state_d = stat_i.dir_valid ? ST_MOVE : ST_DONE;
        end else begin
          cmd_o.look_upd = 1'b1;
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cmd_o.wrap_step = 1'b1;
        if (cnt_q == 5'd8) state_d = ST_LOADY;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_LOADY: begin
        cmd_o.cordic_load = 1'b1;
        state_d = ST_ITERY;
      end
      ST_ITERY: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = ST_SAVEY;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_SAVEY: begin
        cmd_o.trig_save = 1'b1;
        state_d = ST_LOADP;
      end
      ST_LOADP: begin
        cmd_o.cordic_load = 1'b1;
        cmd_o.sel_pitch   = 1'b1;
        state_d = ST_ITERP;
      end
      ST_ITERP: begin
        cmd_o.cordic_step = 1'b1;
        cmd_o.sel_pitch   = 1'b1;
        if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = ST_SAVEP;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_SAVEP: begin
        cmd_o.trig_save = 1'b1;
        cmd_o.sel_pitch = 1'b1;
        state_d = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod_step = 1'b1;
        if (cnt_q == 5'd3) begin
          init_d  = 1'b0;
          state_d = init_q ? ST_IDLE : ST_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_MOVE: begin
        cmd_o.move_step = 1'b1;
        if (cnt_q == 5'd2) state_d = ST_DONE;
        else cnt_d = cnt_q + 5'd1;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/ecu_dpath.sv]
// Datapath of the fly camera core: angles, shared CORDIC, basis and position.
// Depends on ecu_pkg; controlled by ecu_ctrl through ecu_cmd_t.
module ecu_dpath import ecu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ecu_cmd_t      cmd_i,
  output ecu_stat_t     stat_o,
  input  logic [IW-1:0] in_data_i,
  input  logic          in_user_i,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  output logic [DW-1:0] out_data_o
);

  logic               op_q;
  logic signed [15:0] dx_q, dy_q;
  logic [2:0]         dir_q;
  logic [15:0]        dt_q;
  logic [15:0]        sens_q, speed_q;
  logic [31:0]        vel_q;
  logic signed [AW-1:0]   yaw_q;
  logic signed [PW-1:0]   pitch_q;
  logic signed [POSW-1:0] pos_q [3];
  logic signed [RW-1:0]   r_q;
  logic signed [CW-1:0]   x_q, y_q;
  logic signed [AW-1:0]   z_q;
  logic                   neg_q;
  logic signed [TW-1:0]   cy_q, sy_q, cp_q, sp_q;
  logic signed [VW-1:0]   basis_q [9];
  logic [DW-1:0]          out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= SENS_RESET;
      speed_q <= SPEED_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SENS) sens_q <= cfg_data_i;
      else speed_q <= cfg_data_i;
    end
  end

  // Item latch and velocity.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q  <= in_user_i;
      dx_q  <= in_data_i[15:0];
      dy_q  <= in_data_i[31:16];
      dir_q <= in_data_i[34:32];
      dt_q  <= in_data_i[50:35];
    end
    if (cmd_i.vel_load) vel_q <= speed_q * dt_q;
  end

  assign stat_o.op_move   = (op_q == OP_MOVE);
  assign stat_o.dir_valid = (dir_q <= DIR_RIGHT_P);

  // Look arithmetic.
  logic signed [32:0]   yprod, pprod;
  logic signed [33:0]   psum;
  logic signed [PW-1:0] pitch_n;
  logic [3:0]           wsh;
  logic signed [RW-1:0] wstep, r_n;

  always_comb begin
    yprod = dx_q * $signed({1'b0, sens_q});
    pprod = dy_q * $signed({1'b0, sens_q});
    psum  = 34'(pitch_q) + 34'(pprod);
    if (psum > PITCH_LIMIT) pitch_n = PW'(PITCH_LIMIT);
    else if (psum < -PITCH_LIMIT) pitch_n = PW'(-PITCH_LIMIT);
    else pitch_n = PW'(psum);
    wsh   = 4'd8 - cmd_i.idx[3:0];
    wstep = FULL_TURN <<< wsh;
    r_n   = r_q;
    if (cmd_i.idx == 5'd0) begin
      if (r_q < 0) r_n = r_q + (FULL_TURN <<< 8);
    end else if (r_q >= wstep) begin
      r_n = r_q - wstep;
    end
  end

  // CORDIC unit, one rotation a cycle.
  logic signed [AW-1:0] ang, atan_v;
  logic signed [CW-1:0] xs, ys, xc, yc;

  always_comb begin
    ang    = cmd_i.sel_pitch ? AW'(pitch_q) : yaw_q;
    atan_v = $signed({2'b00, atan_lut(cmd_i.idx)});
    xs     = y_q >>> cmd_i.idx;
    ys     = x_q >>> cmd_i.idx;
    if (x_q > TRIG_ONE) xc = TRIG_ONE;
    else if (x_q < -TRIG_ONE) xc = -TRIG_ONE;
    else xc = x_q;
    if (y_q > TRIG_ONE) yc = TRIG_ONE;
    else if (y_q < -TRIG_ONE) yc = -TRIG_ONE;
    else yc = y_q;
    if (neg_q) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_load) begin
      x_q <= CORDIC_X0;
      y_q <= '0;
      if (ang > QUARTER_TURN) begin
        z_q   <= ang - HALF_TURN;
        neg_q <= 1'b1;
      end else if (ang < -QUARTER_TURN) begin
        z_q   <= ang + HALF_TURN;
        neg_q <= 1'b1;
      end else begin
        z_q   <= ang;
        neg_q <= 1'b0;
      end
    end else if (cmd_i.cordic_step) begin
      if (z_q >= 0) begin
        x_q <= x_q - xs;
        y_q <= y_q + ys;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + xs;
        y_q <= y_q - ys;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.trig_save) begin
      if (cmd_i.sel_pitch) begin
        cp_q <= TW'(xc);
        sp_q <= TW'(yc);
      end else begin
        cy_q <= TW'(xc);
        sy_q <= TW'(yc);
      end
    end
  end

  // Basis products, one multiply a cycle.
  logic signed [TW-1:0] ma, mb;
  logic signed [63:0]   prod, prodn, prodr;
  logic signed [VW-1:0] bprod;

  function automatic logic signed [VW-1:0] rnd1(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = (v + (33'sd1 <<< (S1 - 1))) >>> S1;
    return VW'(t);
  endfunction

  always_comb begin
    ma    = cmd_i.idx[0] ? sy_q : cy_q;
    mb    = cmd_i.idx[1] ? sp_q : cp_q;
    prod  = ma * mb;
    prodn = cmd_i.idx[1] ? -prod : prod;
    prodr = (prodn + (64'sd1 <<< (S2 - 1))) >>> S2;
    bprod = VW'(prodr);
  end

  // Move step, one axis a cycle.
  logic [3:0]             mbase;
  logic                   mplus;
  logic signed [VW-1:0]   comp;
  logic signed [MW-1:0]   mprod, mrnd;
  logic signed [POSW+1:0] msum, mclamp;

  always_comb begin
    case (dir_q)
      DIR_FRONT_P: begin mbase = 4'd0; mplus = 1'b1; end
      DIR_FRONT_N: begin mbase = 4'd0; mplus = 1'b0; end
      DIR_UP_P:    begin mbase = 4'd6; mplus = 1'b1; end
      DIR_UP_N:    begin mbase = 4'd6; mplus = 1'b0; end
      DIR_RIGHT_N: begin mbase = 4'd3; mplus = 1'b0; end
      default:     begin mbase = 4'd3; mplus = 1'b1; end
    endcase
    comp  = basis_q[mbase + 4'(cmd_i.idx[1:0])];
    mprod = $signed({1'b0, vel_q}) * comp;
    mrnd  = (mprod + (MW'(1) <<< (15 + VFB))) >>> (16 + VFB);
    if (mplus) msum = 26'(pos_q[cmd_i.idx[1:0]]) + 26'(mrnd);
    else msum = 26'(pos_q[cmd_i.idx[1:0]]) - 26'(mrnd);
    if (msum > POS_MAX) mclamp = POS_MAX;
    else if (msum < POS_MIN) mclamp = POS_MIN;
    else mclamp = msum;
  end

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q    <= YAW_RESET;
      pitch_q  <= '0;
      pos_q[0] <= POS_X_RESET;
      pos_q[1] <= POS_Y_RESET;
      pos_q[2] <= POS_Z_RESET;
    end else begin
      if (cmd_i.look_upd) pitch_q <= pitch_n;
      if (cmd_i.wrap_step) yaw_q <= AW'(r_n - HALF_TURN_R);
      if (cmd_i.move_step) pos_q[cmd_i.idx[1:0]] <= POSW'(mclamp);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_upd) r_q <= RW'(yaw_q) + HALF_TURN_R + RW'(yprod);
    else if (cmd_i.wrap_step) r_q <= r_n;
    if (cmd_i.prod_step) begin
      case (cmd_i.idx[1:0])
        2'd0: begin
          basis_q[0] <= bprod;
          basis_q[1] <= rnd1(33'(sp_q));
          basis_q[3] <= rnd1(-33'(sy_q));
          basis_q[4] <= '0;
          basis_q[5] <= rnd1(33'(cy_q));
          basis_q[7] <= rnd1(33'(cp_q));
        end
        2'd1: basis_q[2] <= bprod;
        2'd2: basis_q[6] <= bprod;
        default: basis_q[8] <= bprod;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= {16'(basis_q[8]), 16'(basis_q[7]), 16'(basis_q[6]),
                16'(basis_q[5]), 16'(basis_q[4]), 16'(basis_q[3]),
                16'(basis_q[2]), 16'(basis_q[1]), 16'(basis_q[0]),
                pos_q[2], pos_q[1], pos_q[0]};
    end
  end

  assign out_data_o = out_q;

endmodule

[rtl/ecu_checker.sv]
// Port-level checker of the fly camera core, bound to the top level.
// Depends on ecu_pkg and the assertion macro header.
`include "euler_fly_camera_update_core_assert.svh"

module ecu_checker import ecu_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [DW-1:0] m_axis_tdata
);

  // A pending result stays offered and unchanged.
  `ECU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ECU_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // The right vector never leaves the horizontal plane.
  `ECU_ASSERT_NOW(a_right_y_zero, m_axis_tvalid, m_axis_tdata[151:136] == 16'd0)

  // Items are worked one at a time, so ready drops right after an accept.
  `ECU_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind euler_fly_camera_update_core ecu_checker u_ecu_checker (.*);
